// ===== hdl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define AST_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/aesr_pkg.sv =====
// shared types, register indexes and the aes s-box table for the encryption round
`default_nettype none

package aesr_pkg;

    localparam int BLOCK_W = 128;
    localparam int HALF_W  = 64;

    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [HALF_W-1:0]  t_half;
    typedef logic [0:0]         t_cfg_idx;

    // configuration register indexes
    localparam t_cfg_idx CFG_KEY_LOW  = 1'b0;
    localparam t_cfg_idx CFG_KEY_HIGH = 1'b1;

    localparam logic [7:0] GF_POLY = 8'h1b;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // multiply by x in gf(2^8)
    function automatic logic [7:0] gf_double(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/aesr_round.sv =====
// combinational aes encryption round: subbytes, shiftrows, mixcolumns, addroundkey
`default_nettype none

module aesr_round (
    input  wire aesr_pkg::t_block i_state,
    input  wire aesr_pkg::t_block i_key,
    output aesr_pkg::t_block      o_state
);
    import aesr_pkg::*;

    logic [7:0] w_sub [16];

    // subbytes with shiftrows folded in: row r of column c reads column c+r
    for (genvar c = 0; c < 4; c++) begin : g_col_sub
        for (genvar r = 0; r < 4; r++) begin : g_row_sub
            localparam int SRC = 4 * ((c + r) % 4) + r;
            assign w_sub[4*c+r] = SBOX[i_state[8*SRC +: 8]];
        end
    end

    for (genvar c = 0; c < 4; c++) begin : g_mix
        logic [7:0] a0, a1, a2, a3;
        logic [7:0] d0, d1, d2, d3;
        assign a0 = w_sub[4*c];
        assign a1 = w_sub[4*c+1];
        assign a2 = w_sub[4*c+2];
        assign a3 = w_sub[4*c+3];
        assign d0 = gf_double(a0);
        assign d1 = gf_double(a1);
        assign d2 = gf_double(a2);
        assign d3 = gf_double(a3);
        assign o_state[32*c    +: 8] = d0 ^ d1 ^ a1 ^ a2 ^ a3 ^ i_key[32*c    +: 8];
        assign o_state[32*c+8  +: 8] = a0 ^ d1 ^ d2 ^ a2 ^ a3 ^ i_key[32*c+8  +: 8];
        assign o_state[32*c+16 +: 8] = a0 ^ a1 ^ d2 ^ d3 ^ a3 ^ i_key[32*c+16 +: 8];
        assign o_state[32*c+24 +: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3 ^ i_key[32*c+24 +: 8];
    end

endmodule

`default_nettype wire

// ===== hdl/aes_encryption_round_top.sv =====
// top level of the single aes encryption round with stream ports and key registers
//
//  channel   dir  width  contents
//  s_axis    in   128    block word: block_low [63:0], block_high [127:64]
//  m_axis    out  128    result word: out_low [63:0], out_high [127:64]
//  cfg       in   64     key write: index 0 round_key_low, index 1 round_key_high
//
// one word per cycle sustained unless the output stalls; the result register drives valid
// the round is one pass of sbox tables and xor trees between the input and result registers
// synchronous active-low reset clears both valid flags and both key halves
// a stalled output holds its word; the input register still fills, then ready drops
`default_nettype none
`include "assert_macros.svh"

module aes_encryption_round_top (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // block word: block_low [63:0], block_high [127:64]
    input  wire aesr_pkg::t_block   i_s_axis_tdata,
    input  wire                     i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // result word: out_low [63:0], out_high [127:64]
    output aesr_pkg::t_block        o_m_axis_tdata,
    output logic                    o_m_axis_tvalid,
    input  wire                     i_m_axis_tready,
    // key write port
    input  wire                     i_cfg_we,
    input  wire aesr_pkg::t_cfg_idx i_cfg_index,
    input  wire aesr_pkg::t_half    i_cfg_wdata
);
    import aesr_pkg::*;

    // round key halves
    t_half  r_key_low, r_key_high;

    // input stage
    logic   r_in_valid, n_in_valid;
    t_block r_in_data;

    // result stage
    logic   r_out_valid, n_out_valid;
    t_block r_out_data;
    t_block w_round;

    logic   w_advance, w_in_fire, w_out_fire;

    // input stage moves on when the result slot is empty or being drained
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_fire      = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_LOW:  r_key_low  <= i_cfg_wdata;
                CFG_KEY_HIGH: r_key_high <= i_cfg_wdata;
            endcase
        end
    end

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_fire) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (w_out_fire) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_data <= i_s_axis_tdata;
        end
        if (w_advance) begin
            r_out_data <= w_round;
        end
    end

    aesr_round u_round (
        .i_state (r_in_data),
        .i_key   ({r_key_high, r_key_low}),
        .o_state (w_round)
    );

    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tvalid = r_out_valid;

    // a full pipe with a stalled output must refuse input
    `AST_SAME(a_full_blocks, i_clk, i_rst_n,
        r_in_valid && r_out_valid && !i_m_axis_tready, !o_s_axis_tready)
    // a word moved into the result stage is offered next cycle
    `AST_NEXT(a_adv_fills, i_clk, i_rst_n, w_advance, o_m_axis_tvalid)
    // a held input word is not dropped
    `AST_NEXT(a_in_kept, i_clk, i_rst_n, r_in_valid && !w_advance, r_in_valid)
    // a taken result with nothing behind it empties the stage
    `AST_NEXT(a_out_drain, i_clk, i_rst_n, w_out_fire && !w_advance, !o_m_axis_tvalid)

endmodule

`default_nettype wire

// ===== bench/aes_encryption_round_top_tb.sv =====
// testbench for the single aes encryption round: stream traffic checked against a local round model
`default_nettype none

module aes_encryption_round_top_tb;

    import aesr_pkg::*;

    localparam int NUM_VECTORS   = 17;
    localparam int NUM_SEGMENTS  = 9;     // three idling modes, three key settings each
    localparam int SEGMENT_WORDS = 111;
    localparam int DRAIN_CYCLES  = 10;    // settling time after the final drain
    localparam int RUN_LIMIT     = 2_000_000;

    // one row of the directed table; res is only meaningful where typed is set
    typedef struct packed {
        t_block blk;
        logic   typed;
        t_block res;
    } t_vector_row;

    // clock and reset
    logic i_clk;
    logic i_rst_n = 1'b0;

    // block stream into the round
    t_block i_s_axis_tdata  = '0;
    logic   i_s_axis_tvalid = 1'b0;
    wire    o_s_axis_tready;

    // result stream out of the round
    wire t_block o_m_axis_tdata;
    wire         o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;

    // key write port
    logic     i_cfg_we    = 1'b0;
    t_cfg_idx i_cfg_index = CFG_KEY_LOW;
    t_half    i_cfg_wdata = '0;

    // local copy of the key registers, tracks every write we make
    t_half key_low_shadow  = '0;
    t_half key_high_shadow = '0;

    // s-box built from the field inverse and the affine map, not taken from the package
    logic [7:0] sub_table [256];

    // rounds accepted on the input side whose word has not come out yet
    t_block pending_rounds [$];

    t_vector_row vectors [NUM_VECTORS];

    int mismatches   = 0;
    int src_idle_pct = 13;
    int snk_idle_pct = 57;

    aes_encryption_round_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop in case the stream hangs
    initial begin
        #RUN_LIMIT;
        $display("tb: failure");
        $finish;
    end

    // multiply by x modulo x^8 + x^4 + x^3 + x + 1
    function automatic logic [7:0] gf_times_x(input logic [7:0] v);
        return (v << 1) ^ ({8{v[7]}} & 8'h1b);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] sh;
        acc = 8'h00;
        sh  = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ sh;
            end
            sh = gf_times_x(sh);
        end
        return acc;
    endfunction

    // inverse as x^254 (zero maps to zero), then the affine map with 0x63
    function automatic void build_sub_table();
        logic [7:0] inv;
        logic [7:0] sq;
        for (int x = 0; x < 256; x++) begin
            sq  = x[7:0];
            inv = 8'h01;
            for (int i = 1; i < 8; i++) begin
                sq  = gf_mul(sq, sq);
                inv = gf_mul(inv, sq);
            end
            sub_table[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                         ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        end
    endfunction

    // subbytes + shiftrows, mixcolumns, then the round key
    function automatic t_block aes_round_of(input t_block blk, input t_half klo,
                                            input t_half khi);
        t_block     key;
        t_block     res;
        logic [7:0] sh [16];
        logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
        key = {khi, klo};
        // row r of column c comes from column c+r
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sh[4*c+r] = sub_table[blk[8*(4*((c+r)%4)+r) +: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = sh[4*c];
            a1 = sh[4*c+1];
            a2 = sh[4*c+2];
            a3 = sh[4*c+3];
            d0 = gf_times_x(a0);
            d1 = gf_times_x(a1);
            d2 = gf_times_x(a2);
            d3 = gf_times_x(a3);
            res[32*c    +: 8] = d0 ^ d1 ^ a1 ^ a2 ^ a3 ^ key[32*c    +: 8];
            res[32*c+8  +: 8] = a0 ^ d1 ^ d2 ^ a2 ^ a3 ^ key[32*c+8  +: 8];
            res[32*c+16 +: 8] = a0 ^ a1 ^ d2 ^ d3 ^ a3 ^ key[32*c+16 +: 8];
            res[32*c+24 +: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3 ^ key[32*c+24 +: 8];
        end
        return res;
    endfunction

    // half fully random words, a quarter built mostly from corner bytes, a quarter with a single column live
    function automatic t_block random_block();
        t_block b;
        int     kind;
        b    = {$urandom, $urandom, $urandom, $urandom};
        kind = $urandom_range(3);
        if (kind == 2) begin
            for (int k = 0; k < 16; k++) begin
                case ($urandom_range(4))
                    0: b[8*k +: 8] = 8'h00;
                    1: b[8*k +: 8] = 8'hff;
                    2: b[8*k +: 8] = 8'h01;
                    3: b[8*k +: 8] = 8'h80;
                    default: ;
                endcase
            end
        end else if (kind == 3) begin
            b = b & ({96'h0, 32'hffffffff} << (32 * $urandom_range(3)));
        end
        return b;
    endfunction

    task automatic report_mismatch(input string what, input t_half got, input t_half want);
        $display("mismatch on %s: got %h, want %h", what, got, want);
        mismatches++;
    endtask

    // offer one block word; returns at the edge that accepts it
    task automatic send_block(input t_block blk, input logic typed, input t_block typed_res);
        t_block want;
        want = typed ? typed_res : aes_round_of(blk, key_low_shadow, key_high_shadow);
        // random gap before the word, with valid low while it lasts
        if ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= blk;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_rounds.push_back(want);
    endtask

    // stop offering and wait until every accepted round has come back
    task automatic drain_rounds();
        i_s_axis_tvalid <= 1'b0;
        while (pending_rounds.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // one key write; the caller drops the write enable after the last one
    task automatic write_key(input t_cfg_idx idx, input t_half val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        if (idx == CFG_KEY_LOW) begin
            key_low_shadow = val;
        end else begin
            key_high_shadow = val;
        end
    endtask

    // output side: random stalls, and every accepted word checked against the oldest round
    always @(posedge i_clk) begin
        t_block want;
        i_m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_rounds.size() == 0) begin
                report_mismatch("unexpected word, out_low", o_m_axis_tdata[63:0], '0);
            end else begin
                want = pending_rounds.pop_front();
                if (o_m_axis_tdata[63:0] !== want[63:0]) begin
                    report_mismatch("out_low", o_m_axis_tdata[63:0], want[63:0]);
                end
                if (o_m_axis_tdata[127:64] !== want[127:64]) begin
                    report_mismatch("out_high", o_m_axis_tdata[127:64], want[127:64]);
                end
            end
        end
    end

    initial begin
        t_half klo;
        t_half khi;

        build_sub_table();

        // directed words; with the key still zero a uniform block gives sbox(byte) everywhere,
        // since mixcolumns leaves a column of equal bytes unchanged
        vectors = '{
            '{{16{8'h00}}, 1'b1, {16{8'h63}}},
            '{{16{8'hff}}, 1'b1, {16{8'h16}}},
            '{{16{8'h01}}, 1'b1, {16{8'h7c}}},
            '{{16{8'h80}}, 1'b1, {16{8'hcd}}},
            '{{16{8'h53}}, 1'b1, {16{8'hed}}},
            // distinct bytes make any shiftrows slip visible
            '{128'h0f0e0d0c0b0a09080706050403020100, 1'b0, '0},
            '{128'h00112233445566778899aabbccddeeff, 1'b0, '0},
            '{{64'h0, {64{1'b1}}}, 1'b0, '0},
            '{{{64{1'b1}}, 64'h0}, 1'b0, '0},
            '{128'h1, 1'b0, '0},
            '{{1'b1, 127'h0}, 1'b0, '0},
            '{{16{8'h55}}, 1'b0, '0},
            '{{16{8'haa}}, 1'b0, '0},
            // one live column at a time, then a full word with all columns live
            '{128'h00000000000000000000000080808080, 1'b0, '0},
            '{128'hffffffff000000000000000000000000, 1'b0, '0},
            '{128'h000000ff000000000000000000000000, 1'b0, '0},
            '{128'h3243f6a8885a308d313198a2e0370734, 1'b0, '0}
        };

        // reset held from the start, released only once
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part runs on the reset key of zero
        for (int v = 0; v < NUM_VECTORS; v++) begin
            send_block(vectors[v].blk, vectors[v].typed, vectors[v].res);
        end

        // random part: receiver slow, then sender slow, then full rate
        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            drain_rounds();
            case (seg / 3)
                0: begin
                    src_idle_pct = 13;
                    snk_idle_pct = 57;
                end
                1: begin
                    src_idle_pct = 57;
                    snk_idle_pct = 13;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            // key extremes first, then an alternating key, then random keys, back to zero at the end
            case (seg)
                0: begin
                    klo = '1;
                    khi = '1;
                end
                1: begin
                    klo = '0;
                    khi = '1;
                end
                2: begin
                    klo = '1;
                    khi = '0;
                end
                3: begin
                    klo = {32{2'b01}};
                    khi = {32{2'b10}};
                end
                NUM_SEGMENTS - 1: begin
                    klo = '0;
                    khi = '0;
                end
                default: begin
                    klo = {$urandom, $urandom};
                    khi = {$urandom, $urandom};
                end
            endcase
            write_key(CFG_KEY_LOW, klo);
            write_key(CFG_KEY_HIGH, khi);
            i_cfg_we <= 1'b0;
            for (int n = 0; n < SEGMENT_WORDS; n++) begin
                send_block(random_block(), 1'b0, '0);
            end
        end

        drain_rounds();
        // keep the output check running to catch stray words
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
